@@ hw/rtl/psjs_pkg.sv @@
// ============================================================================
// psjs_pkg
// Shared widths, request codes and the payload, command and status types
// of the preemptive shortest-job scheduler.
// ============================================================================
`default_nettype none

package psjs_pkg;

    localparam int NUM_W = 16;
    localparam int LEN_W = 32;
    localparam int NOW_W = 32;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic REQ_ARRIVE   = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [NUM_W-1:0] job_number;
        logic [LEN_W-1:0] job_length;
        logic [NOW_W-1:0] now;
    } t_req;

    typedef struct packed {
        logic             accepted;
        logic             cancel_pending;
        logic             schedule_valid;
        logic [NOW_W-1:0] schedule_time;
        logic             done_valid;
        logic [NUM_W-1:0] done_number;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic cap_req;     // latch request, clear result staging and index
        logic idx_inc;     // step the free-slot search
        logic wr_new;      // store arrival at the found slot
        logic start_new;   // arrival becomes the running job
        logic preempt_wb;  // charge elapsed time to the running job, write back
        logic retire;      // retire running job, restart scan
        logic scan_rd;     // read one slot of the scan
        logic start_best;  // best scanned job becomes the running job
        logic stop_run;    // table empty, nothing runs
        logic load_out;    // move staged result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic run_valid;
        logic slot_free;
        logic idx_last;
        logic key_before;
        logic best_any;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/psjs_req_if.sv @@
// ============================================================================
// psjs_req_if
// Request channel: valid/ready handshake with job arrival/completion payload.
// ============================================================================
`default_nettype none

interface psjs_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [psjs_pkg::NUM_W-1:0]   job_number;
    logic [psjs_pkg::LEN_W-1:0]   job_length;
    logic [psjs_pkg::NOW_W-1:0]   now;

    modport source (output valid, req_type, job_number, job_length, now,
                    input ready);
    modport sink   (input valid, req_type, job_number, job_length, now,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/psjs_rsp_if.sv @@
// ============================================================================
// psjs_rsp_if
// Result channel: valid/ready handshake with dispatch result payload.
// ============================================================================
`default_nettype none

interface psjs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic                         cancel_pending;
    logic                         schedule_valid;
    logic [psjs_pkg::NOW_W-1:0]   schedule_time;
    logic                         done_valid;
    logic [psjs_pkg::NUM_W-1:0]   done_number;

    modport source (output valid, accepted, cancel_pending, schedule_valid,
                    schedule_time, done_valid, done_number, input ready);
    modport sink   (input valid, accepted, cancel_pending, schedule_valid,
                    schedule_time, done_valid, done_number, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/psjs_ram.sv @@
// ============================================================================
// psjs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module psjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/psjs_ctrl.sv @@
// ============================================================================
// psjs_ctrl
// Sequencer of the scheduler: accepts one request, walks the free-slot
// search or the retire scan, and hands the staged result to the output.
// ============================================================================
`default_nettype none

module psjs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  wire logic            i_req_type,
    output logic                 o_req_ready,
    input  wire psjs_pkg::t_sts  i_sts,
    output psjs_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND     = 4'd1;
    localparam logic [3:0] S_ARR_WR   = 4'd2;
    localparam logic [3:0] S_PREEMPT  = 4'd3;
    localparam logic [3:0] S_RETIRE   = 4'd4;
    localparam logic [3:0] S_SCAN     = 4'd5;
    localparam logic [3:0] S_SCAN_END = 4'd6;
    localparam logic [3:0] S_PICK     = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.cap_req = 1'b1;
                    if (i_req_type == psjs_pkg::REQ_ARRIVE) begin
                        n_state = S_FIND;
                    end else if (i_sts.run_valid) begin
                        n_state = S_RETIRE;
                    end else begin
                        // completion while idle: all-zero result
                        n_state = S_OUT;
                    end
                end
            end
            S_FIND: begin
                if (i_sts.slot_free) begin
                    n_state = S_ARR_WR;
                end else if (i_sts.idx_last) begin
                    n_state = S_OUT;   // table full, rejected
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_ARR_WR: begin
                o_cmd.wr_new = 1'b1;
                if (!i_sts.run_valid) begin
                    o_cmd.start_new = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.key_before) begin
                    n_state = S_PREEMPT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PREEMPT: begin
                o_cmd.preempt_wb = 1'b1;
                o_cmd.start_new  = 1'b1;
                n_state = S_OUT;
            end
            S_RETIRE: begin
                o_cmd.retire = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // last read data is compared on this cycle
                n_state = S_PICK;
            end
            S_PICK: begin
                if (i_sts.best_any) begin
                    o_cmd.start_best = 1'b1;
                end else begin
                    o_cmd.stop_run = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/psjs_dp.sv @@
// ============================================================================
// psjs_dp
// Datapath of the scheduler: job table (valid flags plus RAM), running-job
// registers, best-candidate tracking for the retire scan, output register.
// ============================================================================
`default_nettype none

module psjs_dp #(
    parameter int QUEUE_DEPTH = psjs_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = psjs_pkg::TIME_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire psjs_pkg::t_req  i_req_data,
    input  wire psjs_pkg::t_cmd  i_cmd,
    output psjs_pkg::t_sts       o_sts,
    output logic                 o_rsp_valid,
    output psjs_pkg::t_rsp       o_rsp_data,
    input  wire logic            i_rsp_ready
);

    localparam int IW     = $clog2(QUEUE_DEPTH);
    localparam int WORD_W = psjs_pkg::NUM_W + psjs_pkg::LEN_W + TIME_BITS;

    function automatic logic key_before(
        input logic [psjs_pkg::LEN_W-1:0] len_a,
        input logic [psjs_pkg::NUM_W-1:0] num_a,
        input logic [psjs_pkg::LEN_W-1:0] len_b,
        input logic [psjs_pkg::NUM_W-1:0] num_b
    );
        logic res;
        if (len_a != len_b) begin
            res = len_a < len_b;
        end else begin
            res = num_a < num_b;
        end
        return res;
    endfunction

    psjs_pkg::t_req r_req;
    psjs_pkg::t_rsp r_stg;

    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [IW-1:0]          r_idx;

    logic                       r_run_valid;
    logic [IW-1:0]              r_run_slot;
    logic [psjs_pkg::LEN_W-1:0] r_run_len;
    logic [psjs_pkg::NUM_W-1:0] r_run_num;
    logic [TIME_BITS-1:0]       r_run_rem;
    logic [TIME_BITS-1:0]       r_start;
    logic [TIME_BITS-1:0]       r_elapsed;

    logic                       r_pend;
    logic [IW-1:0]              r_pend_idx;
    logic                       r_best_any;
    logic [IW-1:0]              r_best_idx;
    logic [psjs_pkg::LEN_W-1:0] r_best_len;
    logic [psjs_pkg::NUM_W-1:0] r_best_num;
    logic [TIME_BITS-1:0]       r_best_rem;

    logic                       r_out_valid;
    psjs_pkg::t_rsp             r_out;

    logic [TIME_BITS-1:0]       now_t;
    logic [TIME_BITS-1:0]       rem_new;
    logic [TIME_BITS-1:0]       wb_rem;
    logic [TIME_BITS-1:0]       sched_new;
    logic [TIME_BITS-1:0]       sched_best;
    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [WORD_W-1:0]          ram_wdata;
    logic [WORD_W-1:0]          ram_rdata;
    logic [psjs_pkg::NUM_W-1:0] rd_num;
    logic [psjs_pkg::LEN_W-1:0] rd_len;
    logic [TIME_BITS-1:0]       rd_rem;
    logic                       take_rd;

    assign now_t   = TIME_BITS'(r_req.now);
    assign rem_new = TIME_BITS'(r_req.job_length);
    assign wb_rem  = (r_run_rem > r_elapsed) ? (r_run_rem - r_elapsed) : '0;

    // completion times wrap at the time width
    assign sched_new  = now_t + rem_new;
    assign sched_best = now_t + r_best_rem;

    assign ram_we    = i_cmd.wr_new | i_cmd.preempt_wb;
    assign ram_waddr = i_cmd.wr_new ? r_idx : r_run_slot;
    assign ram_wdata = i_cmd.wr_new ? {r_req.job_number, r_req.job_length, rem_new}
                                    : {r_run_num, r_run_len, wb_rem};

    psjs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_num  = ram_rdata[WORD_W-1 -: psjs_pkg::NUM_W];
    assign rd_len  = ram_rdata[TIME_BITS +: psjs_pkg::LEN_W];
    assign rd_rem  = ram_rdata[TIME_BITS-1:0];
    // ascending scan with strict compare: ties stay with the lower slot
    assign take_rd = r_pend
                   & (~r_best_any | key_before(rd_len, rd_num, r_best_len, r_best_num));

    assign o_sts.run_valid  = r_run_valid;
    assign o_sts.slot_free  = ~r_valid[r_idx];
    assign o_sts.idx_last   = (r_idx == IW'(QUEUE_DEPTH - 1));
    assign o_sts.key_before = key_before(r_req.job_length, r_req.job_number,
                                         r_run_len, r_run_num);
    assign o_sts.best_any   = r_best_any;
    assign o_sts.out_free   = ~r_out_valid | i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_idx       <= '0;
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_start     <= '0;
            r_pend      <= 1'b0;
            r_best_any  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cap_req || i_cmd.retire) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc || i_cmd.scan_rd) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.wr_new) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.retire) begin
                r_valid[r_run_slot] <= 1'b0;
            end

            if (i_cmd.start_new) begin
                r_run_valid <= 1'b1;
                r_run_slot  <= r_idx;
                r_start     <= now_t;
            end else if (i_cmd.start_best) begin
                r_run_slot  <= r_best_idx;
                r_start     <= now_t;
            end else if (i_cmd.stop_run) begin
                r_run_valid <= 1'b0;
            end

            r_pend <= i_cmd.scan_rd & r_valid[r_idx];

            if (i_cmd.retire) begin
                r_best_any <= 1'b0;
            end else if (take_rd) begin
                r_best_any <= 1'b1;
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_req) begin
            r_req <= i_req_data;
            r_stg <= '0;
        end else begin
            if (i_cmd.wr_new) begin
                r_stg.accepted <= 1'b1;
            end
            if (i_cmd.preempt_wb) begin
                r_stg.cancel_pending <= 1'b1;
            end
            if (i_cmd.start_new) begin
                r_stg.schedule_valid <= 1'b1;
                r_stg.schedule_time  <= psjs_pkg::NOW_W'(sched_new);
            end else if (i_cmd.start_best) begin
                r_stg.schedule_valid <= 1'b1;
                r_stg.schedule_time  <= psjs_pkg::NOW_W'(sched_best);
            end
            if (i_cmd.retire) begin
                r_stg.done_valid  <= 1'b1;
                r_stg.done_number <= r_run_num;
            end
        end

        if (i_cmd.wr_new) begin
            r_elapsed <= (now_t >= r_start) ? (now_t - r_start) : '0;
        end

        if (i_cmd.start_new) begin
            r_run_len <= r_req.job_length;
            r_run_num <= r_req.job_number;
            r_run_rem <= rem_new;
        end else if (i_cmd.start_best) begin
            r_run_len <= r_best_len;
            r_run_num <= r_best_num;
            r_run_rem <= r_best_rem;
        end

        if (i_cmd.scan_rd) begin
            r_pend_idx <= r_idx;
        end
        if (take_rd) begin
            r_best_idx <= r_pend_idx;
            r_best_len <= rd_len;
            r_best_num <= rd_num;
            r_best_rem <= rd_rem;
        end

        if (i_cmd.load_out) begin
            r_out <= r_stg;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/preemptive_shortest_job_scheduler.sv @@
// ============================================================================
// preemptive_shortest_job_scheduler
// Preemptive shortest-job-first dispatcher over a bounded job table.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------------
//  i_req   | in  | i_req.valid / i_req.ready | req_type, job_number, job_length,
//          |     |                           | now
//  o_rsp   | out | o_rsp.valid / o_rsp.ready | accepted, cancel_pending,
//          |     |                           | schedule_valid, schedule_time,
//          |     |                           | done_valid, done_number
//
// One request at a time. An arrival runs the free-slot search one slot per
// cycle, then stores the job and, if it preempts, writes back the running job;
// a completion retires the running job, scans the table one RAM entry per
// cycle and picks the best job, or goes straight to the output when nothing is
// running. A full output register adds its wait on o_rsp.ready. i_req.ready is
// high only when no request is in progress; a result waiting in the output
// register does not hold off the next request, only the delivery of the following
// result. Reset is synchronous, active low, and empties the table at once.
// ============================================================================
`default_nettype none

module preemptive_shortest_job_scheduler #(
    parameter int QUEUE_DEPTH = psjs_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = psjs_pkg::TIME_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    psjs_req_if.sink    i_req,
    psjs_rsp_if.source  o_rsp
);

    psjs_pkg::t_req w_req_data;
    psjs_pkg::t_rsp w_rsp_data;
    psjs_pkg::t_cmd w_cmd;
    psjs_pkg::t_sts w_sts;
    logic           w_req_ready;
    logic           w_rsp_valid;

    assign w_req_data.req_type   = i_req.req_type;
    assign w_req_data.job_number = i_req.job_number;
    assign w_req_data.job_length = i_req.job_length;
    assign w_req_data.now        = i_req.now;
    assign i_req.ready           = w_req_ready;

    assign o_rsp.valid          = w_rsp_valid;
    assign o_rsp.accepted       = w_rsp_data.accepted;
    assign o_rsp.cancel_pending = w_rsp_data.cancel_pending;
    assign o_rsp.schedule_valid = w_rsp_data.schedule_valid;
    assign o_rsp.schedule_time  = w_rsp_data.schedule_time;
    assign o_rsp.done_valid     = w_rsp_data.done_valid;
    assign o_rsp.done_number    = w_rsp_data.done_number;

    psjs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    psjs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (w_req_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (w_rsp_valid),
        .o_rsp_data  (w_rsp_data),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: preemptive shortest-job scheduler
// A table of directed requests (idle completion, equal keys, preemption, clock
// behind start, remaining-time saturation, full table, wrap, slot tie-break)
// is followed by random arrival/completion traffic. Every result beat is compared
// field by field against the result a directed row gives or a scheduler model in the bench.
// ----------------------------------------------------------------------------
module tb;
    import psjs_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int N_RANDOM    = 930;
    localparam int HOLD_AT     = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PAUSE_AT    = 450;

    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp rs;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    psjs_req_if req_ch ();
    psjs_rsp_if rsp_ch ();

    preemptive_shortest_job_scheduler #(
        .QUEUE_DEPTH (DEPTH),
        .TIME_BITS   (TIME_BITS_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // scheduler model state
    bit               tab_valid [DEPTH];
    logic [NUM_W-1:0] tab_num   [DEPTH];
    logic [LEN_W-1:0] tab_len   [DEPTH];
    logic [NOW_W-1:0] tab_rem   [DEPTH];
    bit               run_valid;
    int               run_slot;
    logic [NOW_W-1:0] run_start;

    t_rsp rsp_due_q[$];

    int n_err;
    int n_checked;
    int n_arrive;
    int n_complete;
    int n_preempt;
    int n_reject;
    int n_idle_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit key_lt(logic [LEN_W-1:0] len_a, logic [NUM_W-1:0] num_a,
                                  logic [LEN_W-1:0] len_b, logic [NUM_W-1:0] num_b);
        if (len_a != len_b)
            return len_a < len_b;
        return num_a < num_b;
    endfunction

    // advance the model by one request and return the result it owes
    function automatic t_rsp sjf_dispatch(t_req rq);
        t_rsp             rs;
        int               free_idx;
        int               best;
        bit               found;
        bit               any;
        logic [NOW_W-1:0] elapsed;
        rs = '0;
        if (rq.req_type == REQ_ARRIVE) begin
            n_arrive++;
            found = 1'b0;
            free_idx = 0;
            for (int i = 0; i < DEPTH; i++) begin
                if (!tab_valid[i] && !found) begin
                    free_idx = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                n_reject++;
                return rs;
            end
            tab_valid[free_idx] = 1'b1;
            tab_num[free_idx]   = rq.job_number;
            tab_len[free_idx]   = rq.job_length;
            tab_rem[free_idx]   = rq.job_length;
            rs.accepted = 1'b1;
            if (!run_valid) begin
                run_valid = 1'b1;
                run_slot  = free_idx;
                run_start = rq.now;
                rs.schedule_valid = 1'b1;
                rs.schedule_time  = rq.now + rq.job_length;
            end else if (key_lt(rq.job_length, rq.job_number,
                                tab_len[run_slot], tab_num[run_slot])) begin
                // charge the preempted job, saturating at zero
                elapsed = (rq.now >= run_start) ? rq.now - run_start : '0;
                tab_rem[run_slot] = (tab_rem[run_slot] > elapsed) ?
                                    tab_rem[run_slot] - elapsed : '0;
                run_slot  = free_idx;
                run_start = rq.now;
                n_preempt++;
                rs.cancel_pending = 1'b1;
                rs.schedule_valid = 1'b1;
                rs.schedule_time  = rq.now + rq.job_length;
            end
        end else begin
            n_complete++;
            if (!run_valid) begin
                n_idle_done++;
                return rs;
            end
            rs.done_valid  = 1'b1;
            rs.done_number = tab_num[run_slot];
            tab_valid[run_slot] = 1'b0;
            best = 0;
            any  = 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                if (tab_valid[i] && (!any || key_lt(tab_len[i], tab_num[i],
                                                    tab_len[best], tab_num[best]))) begin
                    best = i;
                    any  = 1'b1;
                end
            end
            if (any) begin
                run_slot  = best;
                run_start = rq.now;
                rs.schedule_valid = 1'b1;
                rs.schedule_time  = rq.now + tab_rem[best];
            end else begin
                run_valid = 1'b0;
            end
        end
        return rs;
    endfunction

    function automatic t_req arrive(logic [NUM_W-1:0] num, logic [LEN_W-1:0] len,
                                    logic [NOW_W-1:0] t);
        t_req rq;
        rq.req_type   = REQ_ARRIVE;
        rq.job_number = num;
        rq.job_length = len;
        rq.now        = t;
        return rq;
    endfunction

    function automatic t_req complete(logic [NOW_W-1:0] t);
        t_req rq;
        rq.req_type   = REQ_COMPLETE;
        rq.job_number = '0;
        rq.job_length = '0;
        rq.now        = t;
        return rq;
    endfunction

    function automatic t_rsp rsp(logic acc, logic cancel, logic sv, logic [NOW_W-1:0] st,
                                 logic dv, logic [NUM_W-1:0] dn);
        t_rsp rs;
        rs.accepted       = acc;
        rs.cancel_pending = cancel;
        rs.schedule_valid = sv;
        rs.schedule_time  = st;
        rs.done_valid     = dv;
        rs.done_number    = dn;
        return rs;
    endfunction

    // one beat on the request channel; call at a rising edge
    task automatic send_req(t_req rq, bit typed, t_rsp typed_rs);
        t_rsp pred;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rq.req_type;
        req_ch.job_number <= rq.job_number;
        req_ch.job_length <= rq.job_length;
        req_ch.now        <= rq.now;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        pred = sjf_dispatch(rq);
        rsp_due_q.push_back(typed ? typed_rs : pred);
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_due_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_err++;
            end else begin
                want = rsp_due_q.pop_front();
                n_checked++;
                check_field("accepted", 32'(want.accepted), 32'(rsp_ch.accepted));
                check_field("cancel_pending", 32'(want.cancel_pending),
                            32'(rsp_ch.cancel_pending));
                check_field("schedule_valid", 32'(want.schedule_valid),
                            32'(rsp_ch.schedule_valid));
                check_field("schedule_time", want.schedule_time, rsp_ch.schedule_time);
                check_field("done_valid", 32'(want.done_valid), 32'(rsp_ch.done_valid));
                check_field("done_number", 32'(want.done_number), 32'(rsp_ch.done_number));
            end
        end
    end

    // result-side backpressure: rotating modes plus one long hold
    initial begin
        int         cyc;
        int         mode;
        logic [7:0] pat;
        cyc  = 0;
        mode = 0;
        pat  = 8'b1011_0010;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == HOLD_AT) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                cyc += HOLD_CYCLES - 1;
            end else begin
                if (cyc % 64 == 0)
                    mode = $urandom_range(0, 3);
                pat = {pat[6:0], pat[7]};
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= pat[0];
                endcase
            end
        end
    end

    initial begin
        t_dir_row         dir_tab [24];
        t_req             rq;
        int               burst_left;
        int               gap;
        int               arrive_pct;
        int               r;
        logic [NOW_W-1:0] sim_now;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_ARRIVE;
        req_ch.job_number = '0;
        req_ch.job_length = '0;
        req_ch.now        = '0;
        rsp_ch.ready      = 1'b0;
        n_err = 0;
        n_checked = 0;
        n_arrive = 0;
        n_complete = 0;
        n_preempt = 0;
        n_reject = 0;
        n_idle_done = 0;
        for (int i = 0; i < DEPTH; i++)
            tab_valid[i] = 1'b0;
        run_valid = 1'b0;
        run_slot  = 0;
        run_start = '0;

        // completion with nothing running
        dir_tab[0]  = '{complete(32'd0), 1'b1,
                        rsp(1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'h0)};
        dir_tab[1]  = '{arrive(16'h0010, 32'd50, 32'd1000), 1'b1,
                        rsp(1'b1, 1'b0, 1'b1, 32'd1050, 1'b0, 16'h0)};
        // same length and id as the running job: no preemption
        dir_tab[2]  = '{arrive(16'h0010, 32'd50, 32'd1010), 1'b1,
                        rsp(1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 16'h0)};
        // lower id wins the tie
        dir_tab[3]  = '{arrive(16'h000F, 32'd50, 32'd1020), 1'b1,
                        rsp(1'b1, 1'b1, 1'b1, 32'd1070, 1'b0, 16'h0)};
        // clock behind the start time
        dir_tab[4]  = '{arrive(16'h0000, 32'd10, 32'd900), 1'b1,
                        rsp(1'b1, 1'b1, 1'b1, 32'd910, 1'b0, 16'h0)};
        // huge elapsed time, remaining saturates
        dir_tab[5]  = '{arrive(16'hFFFF, 32'd0, 32'hFFFF_FFF0), 1'b1,
                        rsp(1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0, 1'b0, 16'h0)};
        dir_tab[6]  = '{complete(32'd5), 1'b1,
                        rsp(1'b0, 1'b0, 1'b1, 32'd5, 1'b1, 16'hFFFF)};
        dir_tab[7]  = '{arrive(16'hAAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                        rsp(1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 16'h0)};
        // fill the table
        dir_tab[8]  = '{arrive(16'h5555, 32'h5555_5555, 32'd6), 1'b0, '0};
        dir_tab[9]  = '{arrive(16'h0001, 32'hAAAA_AAAA, 32'd7), 1'b0, '0};
        dir_tab[10] = '{arrive(16'h0002, 32'd10, 32'd8), 1'b0, '0};
        dir_tab[11] = '{arrive(16'h0003, 32'd11, 32'd9), 1'b0, '0};
        dir_tab[12] = '{arrive(16'h8000, 32'h8000_0000, 32'd10), 1'b0, '0};
        dir_tab[13] = '{arrive(16'h7FFF, 32'h7FFF_FFFF, 32'd11), 1'b0, '0};
        dir_tab[14] = '{arrive(16'h0004, 32'd60, 32'd12), 1'b0, '0};
        dir_tab[15] = '{arrive(16'h0005, 32'd60, 32'd13), 1'b0, '0};
        dir_tab[16] = '{arrive(16'h0006, 32'd70, 32'd14), 1'b0, '0};
        dir_tab[17] = '{arrive(16'h0007, 32'd80, 32'd15), 1'b0, '0};
        dir_tab[18] = '{arrive(16'h0008, 32'd90, 32'd16), 1'b0, '0};
        // table full
        dir_tab[19] = '{arrive(16'h0009, 32'd1, 32'd17), 1'b1,
                        rsp(1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'h0)};
        // completion time wraps past the top of the time range
        dir_tab[20] = '{complete(32'hFFFF_FFFF), 1'b0, '0};
        dir_tab[21] = '{complete(32'd20), 1'b0, '0};
        dir_tab[22] = '{complete(32'd30), 1'b0, '0};
        // equal keys in two slots go to the lower slot
        dir_tab[23] = '{complete(32'd40), 1'b0, '0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rs);

        sim_now    = 32'd100;
        burst_left = 0;
        gap        = 0;
        arrive_pct = 50;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) begin
                r = $urandom_range(0, 2);
                arrive_pct = (r == 0) ? 85 : (r == 1) ? 50 : 25;
            end
            r = $urandom_range(0, 31);
            if (r == 0)
                sim_now = $urandom;
            else if (r < 3)
                sim_now = sim_now - $urandom_range(0, 100);
            else
                sim_now = sim_now + $urandom_range(0, 40);
            rq.now = sim_now;
            rq.req_type = ($urandom_range(0, 99) < arrive_pct) ? REQ_ARRIVE : REQ_COMPLETE;
            r = $urandom_range(0, 15);
            rq.job_length = (r < 12) ? $urandom_range(1, 60) :
                            (r == 12) ? 32'd0 :
                            (r == 13) ? 32'hFFFF_FFFF : $urandom;
            rq.job_number = ($urandom_range(0, 15) < 12) ? NUM_W'($urandom_range(0, 7))
                                                         : NUM_W'($urandom);
            send_req(rq, 1'b0, '0);

            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
            if (n == PAUSE_AT) begin
                // let the block drain completely before going on
                req_ch.valid <= 1'b0;
                while (rsp_due_q.size() != 0)
                    @(posedge i_clk);
            end else if (burst_left == 0 && gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (req_ch.valid)
            req_ch.valid <= 1'b0;

        while (rsp_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 10) @(posedge i_clk);

        $display("%0d results checked: %0d arrivals (%0d preempting, %0d rejected on full table)",
                 n_checked, n_arrive, n_preempt, n_reject);
        $display("%0d completion requests, %0d of them with nothing running",
                 n_complete, n_idle_done);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
